// ===== rtl/md4_pkg.sv =====
// ----------------------------------------------------------------------------
// md4_pkg
// Shared types, constants and round tables for the MD4 digest unit.
// ----------------------------------------------------------------------------
package md4_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [3:0][31:0] cv_t;

  // initial chaining value, word A in slice 0
  localparam cv_t IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  localparam word_t K_RND1  = 32'h5A827999;
  localparam word_t K_RND2  = 32'h6ED9EBA1;
  localparam word_t PAD_BYTE = 32'h00000080;

  localparam logic [5:0] ROUND_LAST = 6'd47;
  localparam logic [3:0] POS_LAST   = 4'd15;
  localparam logic [3:0] POS_LEN    = 4'd14;
  localparam logic [2:0] FULL_BYTES = 3'd4;

  // source of the word written into the block buffer
  typedef enum logic [2:0] {
    WS_INPUT  = 3'd0,
    WS_PAD80  = 3'd1,
    WS_ZERO   = 3'd2,
    WS_LEN_LO = 3'd3,
    WS_LEN_HI = 3'd4
  } wsrc_t;

  // sequencer to datapath
  typedef struct packed {
    logic       take;
    logic       wr_en;
    wsrc_t      wr_src;
    logic       round_en;
    logic [5:0] rnd_idx;
    logic       add_en;
    logic       emit_en;
  } ctrl_t;

  // datapath and output buffer back to sequencer
  typedef struct packed {
    logic [3:0] pos;
    logic       obuf_busy;
  } stat_t;

  localparam logic [3:0] MSG_ORDER [48] = '{
    4'd0, 4'd1, 4'd2,  4'd3,  4'd4, 4'd5, 4'd6,  4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd0, 4'd4, 4'd8,  4'd12, 4'd1, 4'd5, 4'd9,  4'd13,
    4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15,
    4'd0, 4'd8, 4'd4,  4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
    4'd1, 4'd9, 4'd5,  4'd13, 4'd3, 4'd11, 4'd7, 4'd15
  };

  function automatic logic [3:0] msg_index(input logic [5:0] idx);
    logic [3:0] m;
    m = 4'd0;
    if (idx <= ROUND_LAST) begin
      m = MSG_ORDER[idx];
    end
    return m;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] idx);
    logic [4:0] s;
    unique case ({idx[5:4], idx[1:0]})
      4'b00_00: s = 5'd3;
      4'b00_01: s = 5'd7;
      4'b00_10: s = 5'd11;
      4'b00_11: s = 5'd19;
      4'b01_00: s = 5'd3;
      4'b01_01: s = 5'd5;
      4'b01_10: s = 5'd9;
      4'b01_11: s = 5'd13;
      4'b10_00: s = 5'd3;
      4'b10_01: s = 5'd9;
      4'b10_10: s = 5'd11;
      4'b10_11: s = 5'd15;
      default:  s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/md4_useq.sv =====
// ----------------------------------------------------------------------------
// md4_useq
// Microcode sequencer: step counter, control store, round counter and
// return register for the compression routine.
// ----------------------------------------------------------------------------
module md4_useq
  import md4_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  input  logic [2:0] in_byte_count,
  input  stat_t      stat,
  output logic       in_stall,
  output ctrl_t      ctrl
);

  typedef logic [2:0] step_t;

  typedef enum logic [2:0] {
    JC_NEXT  = 3'd0,
    JC_GOTO  = 3'd1,
    JC_INPUT = 3'd2,
    JC_POS14 = 3'd3,
    JC_ROUND = 3'd4,
    JC_RET   = 3'd5,
    JC_OBUF  = 3'd6
  } jc_t;

  typedef struct packed {
    logic  accept;
    logic  wr;
    wsrc_t wr_src;
    jc_t   jc;
    step_t target;
    logic  round;
    logic  add;
    logic  emit;
  } ucode_t;

  localparam step_t S_ACCEPT = 3'd0;
  localparam step_t S_PAD    = 3'd1;
  localparam step_t S_FILL   = 3'd2;
  localparam step_t S_LENLO  = 3'd3;
  localparam step_t S_LENHI  = 3'd4;
  localparam step_t S_EMIT   = 3'd5;
  localparam step_t S_ROUND  = 3'd6;
  localparam step_t S_ADD    = 3'd7;

  // control store
  function automatic ucode_t ucode_rom(input step_t a);
    ucode_t u;
    u = '{accept: 1'b0, wr: 1'b0, wr_src: WS_ZERO, jc: JC_NEXT, target: S_ACCEPT,
          round: 1'b0, add: 1'b0, emit: 1'b0};
    unique case (a)
      S_ACCEPT: begin
        u.accept = 1'b1;
        u.wr     = 1'b1;
        u.wr_src = WS_INPUT;
        u.jc     = JC_INPUT;
        u.target = S_PAD;
      end
      S_PAD: begin
        u.wr     = 1'b1;
        u.wr_src = WS_PAD80;
      end
      S_FILL: begin
        u.wr     = 1'b1;
        u.wr_src = WS_ZERO;
        u.jc     = JC_POS14;
        u.target = S_LENLO;
      end
      S_LENLO: begin
        u.wr     = 1'b1;
        u.wr_src = WS_LEN_LO;
      end
      S_LENHI: begin
        u.wr     = 1'b1;
        u.wr_src = WS_LEN_HI;
        u.jc     = JC_GOTO;
        u.target = S_EMIT;
      end
      S_EMIT: begin
        u.emit   = 1'b1;
        u.jc     = JC_OBUF;
        u.target = S_ACCEPT;
      end
      S_ROUND: begin
        u.round = 1'b1;
        u.jc    = JC_ROUND;
      end
      S_ADD: begin
        u.add = 1'b1;
        u.jc  = JC_RET;
      end
      default: ;
    endcase
    return u;
  endfunction

  step_t      step_r, step_nxt;
  step_t      ret_r, ret_nxt;
  logic [5:0] rcnt_r, rcnt_nxt;

  ucode_t uc;
  step_t  nat_nxt;
  logic   take;
  logic   act;
  logic   wr_en;
  logic   blk_full;

  always_comb begin
    uc       = ucode_rom(step_r);
    in_stall = !uc.accept;
    take     = in_valid && uc.accept;

    unique case (uc.jc)
      JC_NEXT: begin
        act     = 1'b1;
        nat_nxt = step_r + 3'd1;
      end
      JC_GOTO: begin
        act     = 1'b1;
        nat_nxt = uc.target;
      end
      JC_INPUT: begin
        act = take;
        if (!take || !in_last) begin
          nat_nxt = step_r;
        end else if (in_byte_count >= FULL_BYTES) begin
          nat_nxt = uc.target;
        end else begin
          nat_nxt = S_FILL;
        end
      end
      JC_POS14: begin
        // zero fill up to the length words, no write on the exit step
        act     = (stat.pos != POS_LEN);
        nat_nxt = act ? step_r : uc.target;
      end
      JC_ROUND: begin
        act     = 1'b1;
        nat_nxt = (rcnt_r == ROUND_LAST) ? step_r + 3'd1 : step_r;
      end
      JC_RET: begin
        act     = 1'b1;
        nat_nxt = ret_r;
      end
      JC_OBUF: begin
        act     = !stat.obuf_busy;
        nat_nxt = act ? uc.target : step_r;
      end
      default: begin
        act     = 1'b0;
        nat_nxt = S_ACCEPT;
      end
    endcase

    wr_en    = uc.wr && act;
    // a write into the last slot closes the block: call the compression
    blk_full = wr_en && (stat.pos == POS_LAST);
    step_nxt = blk_full ? S_ROUND : nat_nxt;
    ret_nxt  = blk_full ? nat_nxt : ret_r;

    if (uc.round) begin
      rcnt_nxt = (rcnt_r == ROUND_LAST) ? 6'd0 : rcnt_r + 6'd1;
    end else begin
      rcnt_nxt = rcnt_r;
    end

    ctrl.take     = take;
    ctrl.wr_en    = wr_en;
    ctrl.wr_src   = uc.wr_src;
    ctrl.round_en = uc.round;
    ctrl.rnd_idx  = rcnt_r;
    ctrl.add_en   = uc.add;
    ctrl.emit_en  = uc.emit && act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_ACCEPT;
      ret_r  <= S_ACCEPT;
      rcnt_r <= 6'd0;
    end else begin
      step_r <= step_nxt;
      ret_r  <= ret_nxt;
      rcnt_r <= rcnt_nxt;
    end
  end

endmodule

// ===== rtl/md4_dpath.sv =====
// ----------------------------------------------------------------------------
// md4_dpath
// Block buffer, word position, byte length, chaining value and the
// one-round-per-cycle MD4 round unit.
// ----------------------------------------------------------------------------
module md4_dpath
  import md4_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_t      ctrl,
  input  word_t      in_data_word,
  input  logic [2:0] in_byte_count,
  input  logic       in_last,
  output logic [3:0] pos,
  output cv_t        cv
);

  word_t       buf_r [16];
  logic [3:0]  pos_r, pos_nxt;
  logic [60:0] len_r, len_nxt;
  cv_t         cv_r, cv_nxt;
  cv_t         wk_r, wk_nxt;

  word_t       in_word;
  word_t       wr_val;
  logic [2:0]  len_inc;
  word_t       w_msg;
  word_t       f_val;
  word_t       t_sum;
  logic [63:0] t_rot;
  logic [1:0]  rnd;

  // input word, padded in place when the last word is short
  always_comb begin
    if (!in_last || in_byte_count >= FULL_BYTES) begin
      in_word = in_data_word;
      len_inc = in_last ? FULL_BYTES : FULL_BYTES;
    end else begin
      len_inc = in_byte_count;
      unique case (in_byte_count[1:0])
        2'd0:    in_word = PAD_BYTE;
        2'd1:    in_word = {16'h0000, 8'h80, in_data_word[7:0]};
        2'd2:    in_word = {8'h00, 8'h80, in_data_word[15:0]};
        default: in_word = {8'h80, in_data_word[23:0]};
      endcase
    end
    unique case (ctrl.wr_src)
      WS_INPUT:  wr_val = in_word;
      WS_PAD80:  wr_val = PAD_BYTE;
      WS_LEN_LO: wr_val = {len_r[28:0], 3'b000};
      WS_LEN_HI: wr_val = len_r[60:29];
      default:   wr_val = '0;
    endcase
  end

  // one MD4 round
  always_comb begin
    rnd   = ctrl.rnd_idx[5:4];
    w_msg = buf_r[msg_index(ctrl.rnd_idx)];
    unique case (rnd)
      2'd0:    f_val = (wk_r[1] & wk_r[2]) | (~wk_r[1] & wk_r[3]);
      2'd1:    f_val = ((wk_r[1] & wk_r[2]) | (wk_r[1] & wk_r[3]) | (wk_r[2] & wk_r[3]))
                       + K_RND1;
      default: f_val = (wk_r[1] ^ wk_r[2] ^ wk_r[3]) + K_RND2;
    endcase
    t_sum = wk_r[0] + f_val + w_msg;
    t_rot = {t_sum, t_sum} << rot_amount(ctrl.rnd_idx);
  end

  always_comb begin
    pos_nxt = pos_r;
    len_nxt = len_r;
    cv_nxt  = cv_r;
    wk_nxt  = wk_r;
    if (ctrl.wr_en) begin
      pos_nxt = pos_r + 4'd1;
    end
    if (ctrl.take) begin
      len_nxt = len_r + {58'd0, len_inc};
    end
    if (ctrl.round_en) begin
      wk_nxt[0] = wk_r[3];
      wk_nxt[1] = t_rot[63:32];
      wk_nxt[2] = wk_r[1];
      wk_nxt[3] = wk_r[2];
    end
    if (ctrl.add_en) begin
      for (int i = 0; i < 4; i++) begin
        cv_nxt[i] = cv_r[i] + wk_r[i];
        wk_nxt[i] = cv_r[i] + wk_r[i];
      end
    end
    if (ctrl.emit_en) begin
      // digest handed off, restart for the next message
      cv_nxt  = IV;
      wk_nxt  = IV;
      len_nxt = '0;
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
      cv_r  <= IV;
      wk_r  <= IV;
    end else begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      cv_r  <= cv_nxt;
      wk_r  <= wk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      buf_r[pos_r] <= wr_val;
    end
  end

  assign pos = pos_r;
  assign cv  = cv_r;

endmodule

// ===== rtl/md4_obuf.sv =====
// ----------------------------------------------------------------------------
// md4_obuf
// Output buffer: holds the four digest words and shifts them out.
// ----------------------------------------------------------------------------
module md4_obuf
  import md4_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  cv_t        cv,
  input  logic       out_stall,
  output logic       out_valid,
  output word_t      out_digest_word,
  output logic [1:0] out_word_index,
  output logic       out_final_word
);

  cv_t        sh_r, sh_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic       fire;

  always_comb begin
    fire    = vld_r && !out_stall;
    sh_nxt  = sh_r;
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      sh_nxt  = cv;
      idx_nxt = 2'd0;
      vld_nxt = 1'b1;
    end else if (fire) begin
      sh_nxt  = {32'h0, sh_r[3:1]};
      idx_nxt = idx_r + 2'd1;
      vld_nxt = (idx_r != 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  assign out_valid       = vld_r;
  assign out_digest_word = sh_r[0];
  assign out_word_index  = idx_r;
  assign out_final_word  = (idx_r == 2'd3);

endmodule

// ===== rtl/md4_message_digest_unit.sv =====
// ----------------------------------------------------------------------------
// md4_message_digest_unit
// MD4 digest of a byte stream given as little-endian 32-bit words.
// ----------------------------------------------------------------------------
//
//  channel | dir | ports                                          | request
//  --------+-----+------------------------------------------------+--------------------
//  in_     | in  | valid, stall, data_word, byte_count, last      | one message word
//  out_    | out | valid, stall, digest_word, word_index, final   | one digest word
//
//  a non-last word is written straight into the block buffer; the word that fills a block
//  starts the compression (48 rounds in the shared round unit, one per cycle, then a fold
//  into the chaining value)
//  a last word runs the padding program: pad, zero and length words, a step leaving the
//  zero fill without a write, a compression per block closed (one or two), then the
//  handoff once the digest buffer is empty
//  reset (rst_n low, synchronous) loads the initial vector, clears length
//  and word position; the block buffer is not cleared
//  in_stall is high whenever the sequencer is off the accept step; the
//  digest waits in its own buffer, so a new message starts while it drains
//
module md4_message_digest_unit
  import md4_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_final_word
);

  ctrl_t      ctrl;
  stat_t      stat;
  logic [3:0] pos;
  cv_t        cv;

  // status fed back to the control store's jump logic
  assign stat.pos       = pos;
  assign stat.obuf_busy = out_valid;

  // step counter and control store
  md4_useq u_useq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last       (in_last),
    .in_byte_count (in_byte_count),
    .stat          (stat),
    .in_stall      (in_stall),
    .ctrl          (ctrl)
  );

  // buffer, length, chaining value, round unit
  md4_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .pos           (pos),
    .cv            (cv)
  );

  // digest words out, A first
  md4_obuf u_obuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (ctrl.emit_en),
    .cv              (cv),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_final_word  (out_final_word)
  );

  // digest only appears after a handoff step
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctrl.emit_en))
    else $error("digest output without handoff");

  // handoff never overwrites a digest still draining
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit_en |-> !out_valid)
    else $error("handoff while digest buffer busy");

  // rounds only run on a closed block, word position wrapped to zero
  a_round_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.round_en || ctrl.add_en) |-> (pos == 4'd0))
    else $error("compression with open block");

  // the four digest words go out back to back in order
  a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_final_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 2'd1))
    else $error("digest word sequence broken");

endmodule

// ===== sim/md4_message_digest_unit_tb.sv =====
// ----------------------------------------------------------------------------
// md4_message_digest_unit_tb
// Self-checking bench for the streaming MD4 digest unit. Word requests are
// fed through a valid/stall handshake. An in-bench MD4 predictor queues the
// four digest words that each last word should produce, and every digest
// request leaving the unit is compared field by field against that queue.
// ----------------------------------------------------------------------------
module md4_message_digest_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import md4_pkg::word_t;

  // run limits
  localparam int unsigned QUIET_LIMIT  = 3000;  // cycles with no handshake at all
  localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 150;   // two compressions plus padding

  // one digest word as it should leave the unit
  typedef struct {
    word_t      word;
    logic [1:0] index;
    logic       fin;
  } digest_t;

  // dut ports, all inputs known from time zero
  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [31:0] in_data_word  = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_last       = 1'b0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [31:0] out_digest_word;
  logic [1:0]  out_word_index;
  logic        out_final_word;

  // predictor state: chaining value, block under construction, length
  word_t       digest_chain [4];
  word_t       msg_block [16];
  logic [3:0]  block_pos;
  logic [60:0] msg_bytes;

  // digest words still owed by the unit, oldest first
  digest_t     pending_digest [$];
  digest_t     due;

  // traffic shaping
  bit          idle_on = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;

  // bookkeeping
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned messages_sent = 0;
  int unsigned digests_checked = 0;
  int unsigned quiet_cycles = 0;

  md4_message_digest_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_final_word  (out_final_word)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // md4 predictor
  // ---------------------------------------------------------------------------

  // back to the initial vector, empty block, zero length
  function automatic void md4_restart();
    digest_chain[0] = 32'h67452301;
    digest_chain[1] = 32'hefcdab89;
    digest_chain[2] = 32'h98badcfe;
    digest_chain[3] = 32'h10325476;
    block_pos = 4'd0;
    msg_bytes = '0;
  endfunction

  // 48 rounds over the full block, then fold into the chaining value
  function automatic void md4_compress();
    int unsigned shift_tab [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};
    word_t       a, b, c, d, f, t;
    int          r;
    int unsigned grp;
    int unsigned s;
    logic [3:0]  j;
    logic [3:0]  pick;
    a = digest_chain[0];
    b = digest_chain[1];
    c = digest_chain[2];
    d = digest_chain[3];
    for (r = 0; r < 48; r++) begin
      grp = r / 16;
      j   = r[3:0];
      // word order: straight, then column-wise, then bit-reversed
      if (grp == 0) begin
        f    = (b & c) | (~b & d);
        pick = j;
      end else if (grp == 1) begin
        f    = ((b & c) | (b & d) | (c & d)) + 32'h5A827999;
        pick = {j[1:0], j[3:2]};
      end else begin
        f    = (b ^ c ^ d) + 32'h6ED9EBA1;
        pick = {j[0], j[1], j[2], j[3]};
      end
      s = shift_tab[grp * 4 + (r % 4)];
      t = a + f + msg_block[pick];
      t = (t << s) | (t >> (32 - s));
      a = d;
      d = c;
      c = b;
      b = t;
    end
    digest_chain[0] += a;
    digest_chain[1] += b;
    digest_chain[2] += c;
    digest_chain[3] += d;
  endfunction

  // place one word, compress when the block fills
  function automatic void md4_absorb(input word_t w);
    msg_block[block_pos] = w;
    block_pos = block_pos + 4'd1;
    if (block_pos == 4'd0) begin
      md4_compress();
    end
  endfunction

  // effect of one accepted word request; a last word queues four digest words
  function automatic void md4_predict_word(input word_t data, input logic [2:0] count,
                                           input logic fin);
    logic [2:0]  n;
    word_t       keep;
    word_t       pad;
    logic [63:0] bit_len;
    digest_t     dw;
    int          k;
    if (!fin) begin
      // count is ignored on inner words
      msg_bytes = msg_bytes + 61'd4;
      md4_absorb(data);
      return;
    end
    n = (count > 3'd4) ? 3'd4 : count;
    msg_bytes = msg_bytes + 61'(n);
    if (n == 3'd4) begin
      md4_absorb(data);
      pad = 32'h00000080;
    end else begin
      // drop unused bytes, then the 0x80 marker right after the last one
      keep = ~(32'hFFFFFFFF << (8 * n));
      pad  = (data & keep) | (32'h00000080 << (8 * n));
    end
    md4_absorb(pad);
    // no room for the length: finish this block with zeros
    if (block_pos == 4'd15) begin
      md4_absorb('0);
    end
    while (block_pos < 4'd14) begin
      md4_absorb('0);
    end
    bit_len = {msg_bytes, 3'b000};
    md4_absorb(bit_len[31:0]);
    md4_absorb(bit_len[63:32]);
    for (k = 0; k < 4; k++) begin
      dw.word  = digest_chain[k];
      dw.index = 2'(k);
      dw.fin   = (k == 3);
      pending_digest.push_back(dw);
    end
    md4_restart();
  endfunction

  // ---------------------------------------------------------------------------
  // digest side: random stall bursts, plus the long hold-off when requested
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (holds_done != hold_requests) begin
      holds_done <= hold_requests;
      hold_left  <= HOLD_CYCLES - 1;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      // start a stall burst of random length
      burst_left <= $urandom_range(0, 3);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // digest checker: each accepted digest request against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_digest.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d final %b", $time,
                 out_digest_word, out_word_index, out_final_word);
        errors++;
      end else begin
        due = pending_digest.pop_front();
        digests_checked++;
        if (out_digest_word !== due.word) begin
          $display("%0t: digest_word expected %h actual %h", $time,
                   due.word, out_digest_word);
          errors++;
        end
        if (out_word_index !== due.index) begin
          $display("%0t: word_index expected %0d actual %0d", $time,
                   due.index, out_word_index);
          errors++;
        end
        if (out_final_word !== due.fin) begin
          $display("%0t: final_word expected %b actual %b", $time,
                   due.fin, out_final_word);
          errors++;
        end
      end
    end
  end

  // watchdog: too long with no handshake on either channel ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d digest words outstanding",
                 $time, QUIET_LIMIT, pending_digest.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // word requests
  // ---------------------------------------------------------------------------

  // random data with the all-zero and all-one words mixed in
  function automatic word_t pick_data();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      return 32'h00000000;
    end else if (sel == 1) begin
      return 32'hFFFFFFFF;
    end
    return $urandom;
  endfunction

  // offer one word request, hold it steady until taken; called at a falling edge
  task automatic send_word(input word_t data, input logic [2:0] count, input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data_word  <= data;
    in_byte_count <= count;
    in_last       <= fin;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    md4_predict_word(data, count, fin);
    words_sent++;
    if (fin) messages_sent++;
    @(negedge clk);
  endtask

  // inner words mostly full, count sometimes junk (ignored), then a last word
  task automatic send_message(input int unsigned n_words);
    int unsigned k;
    logic [2:0]  cnt;
    for (k = 1; k < n_words; k++) begin
      cnt = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      send_word(pick_data(), cnt, 1'b0);
    end
    send_word(pick_data(), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // single-word messages: every byte count, garbage in the unused bytes
  task automatic test_short_messages();
    send_word(32'hFFFFFFFF, 3'd0, 1'b1);   // empty message
    send_word(32'hFFFFFF61, 3'd1, 1'b1);   // "a"
    send_word(32'hA5A56261, 3'd2, 1'b1);   // "ab"
    send_word(32'hFF636261, 3'd3, 1'b1);   // "abc"
    send_word(32'h00000000, 3'd4, 1'b1);   // full last word
    send_word(32'hFFFFFFFF, 3'd5, 1'b1);   // counts above four act as four
    send_word($urandom,     3'd6, 1'b1);
    send_word($urandom,     3'd7, 1'b1);
  endtask

  // 14 full words and a short last word: the pad byte leaves no room for the
  // length, so a second block of zeros and length follows
  task automatic test_extra_pad_block();
    int unsigned k;
    logic [2:0]  cnt;
    for (k = 0; k < 14; k++) begin
      cnt = (k == 3) ? 3'd0 : ((k == 7) ? 3'd7 : 3'd4);   // ignored on inner words
      send_word((k % 2 == 0) ? 32'hFFFFFFFF : 32'h00000000, cnt, 1'b0);
    end
    send_word(32'h5A5A5A5A, 3'd3, 1'b1);
  endtask

  // random well-formed messages, lengths clustered around block boundaries
  task automatic test_random_messages(input int unsigned budget);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(13, 17);
      end else if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(18, 34);
      end else begin
        n = $urandom_range(1, 12);
      end
      send_message(n);
      sent += n;
    end
  endtask

  // digest side holds off while short messages keep coming, so the digest
  // buffer fills and the unit must stall word requests
  task automatic test_output_hold();
    int unsigned k;
    hold_requests++;
    for (k = 0; k < 4; k++) begin
      send_message($urandom_range(1, 3));
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    md4_restart();
    // synchronous reset, released at a falling edge
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_short_messages();
    test_extra_pad_block();
    test_random_messages(90);
    test_output_hold();
    // closing stretch at full rate on both sides
    idle_on = 1'b0;
    test_random_messages(30);
    in_valid <= 1'b0;

    // drain, then allow for anything the unit might still emit
    while (pending_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered: empty and short last words, oversized counts, pad spill into a");
    $display("second block, %0d messages / %0d words, %0d digest words, %0d mismatches",
             messages_sent, words_sent, digests_checked, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
